/* sv/rc4_pkg.sv */
// Shared types and codes for the RC4 stream cipher block.
package rc4_pkg;

    localparam int TABLE_AW = 8;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SCHED  = 2'd1,
        CMD_ENC    = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD,
        ST_KS_ACC,
        ST_KS_W1,
        ST_KS_W2,
        ST_ENC_J,
        ST_ENC_SW,
        ST_ENC_OUT
    } t_state;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_KEY_WR,
        DP_SCHED_INIT,
        DP_FILL,
        DP_KS_RD,
        DP_KS_ACC,
        DP_KS_W1,
        DP_KS_W2,
        DP_ENC_INIT,
        DP_ENC_J,
        DP_ENC_SW,
        DP_ENC_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_last;
    } t_dp_sts;

endpackage

/* sv/rc4_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read returns the old contents on an address collision
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/rc4_dp.sv */
// RC4 datapath: indices, swap registers, key and permutation memories, output byte.
module rc4_dp
    import rc4_pkg::*;
#(
    parameter int KEY_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  logic [7:0] i_key_index,
    input  logic [7:0] i_key_byte,
    input  logic [7:0] i_data_byte,
    output logic [7:0] o_out_byte
);

    localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    logic [7:0]    r_i, n_i;
    logic [7:0]    r_j, n_j;
    logic [7:0]    r_si, n_si;
    logic [7:0]    r_sj, n_sj;
    logic [7:0]    r_t, n_t;
    logic [7:0]    r_data, n_data;
    logic [7:0]    r_obyte, n_obyte;
    logic [KW-1:0] r_kpos, n_kpos;

    logic                p_we, p_re;
    logic [TABLE_AW-1:0] p_waddr, p_raddr;
    logic [7:0]          p_wdata, p_rdata;
    logic                k_we, k_re;
    logic [KW-1:0]       k_waddr;
    logic [7:0]          k_rdata;

    logic [7:0]    i_next, jj, tt, acc, ks;
    logic [KW-1:0] kpos_next;
    logic          key_in_range;

    rc4_ram #(.WIDTH(8), .DEPTH(256)) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    rc4_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (k_waddr),
        .i_wdata (i_key_byte),
        .i_re    (k_re),
        .i_raddr (r_kpos),
        .o_rdata (k_rdata)
    );

    assign i_next       = 8'(r_i + 8'd1);
    assign jj           = 8'(r_j + p_rdata);
    assign tt           = 8'(r_si + p_rdata);
    assign acc          = 8'(r_j + p_rdata + k_rdata);
    assign kpos_next    = (r_kpos == KW'(KEY_BYTES - 1)) ? '0 : KW'(r_kpos + 1'b1);
    assign key_in_range = ({1'b0, i_key_index} < 9'(KEY_BYTES));
    assign k_waddr      = i_key_index[KW-1:0];

    // Writes of S[i] and S[j] still missing from the registered read of S[t]
    always_comb begin
        priority if (r_t == r_i) begin
            ks = r_sj;
        end else if (r_t == r_j) begin
            ks = r_si;
        end else begin
            ks = p_rdata;
        end
    end

    always_comb begin
        n_i     = r_i;
        n_j     = r_j;
        n_si    = r_si;
        n_sj    = r_sj;
        n_t     = r_t;
        n_data  = r_data;
        n_obyte = r_obyte;
        n_kpos  = r_kpos;
        p_we    = 1'b0;
        p_waddr = r_i;
        p_wdata = r_i;
        p_re    = 1'b0;
        p_raddr = r_i;
        k_we    = 1'b0;
        k_re    = 1'b0;
        unique case (i_cmd.op)
            DP_NOP: begin
            end
            DP_KEY_WR: begin
                k_we = key_in_range;
            end
            DP_SCHED_INIT: begin
                n_i    = '0;
                n_j    = '0;
                n_kpos = '0;
            end
            DP_FILL: begin
                p_we = 1'b1;
                n_i  = i_next;
            end
            DP_KS_RD: begin
                p_re = 1'b1;
                k_re = 1'b1;
            end
            DP_KS_ACC: begin
                n_si    = p_rdata;
                n_j     = acc;
                p_re    = 1'b1;
                p_raddr = acc;
            end
            DP_KS_W1: begin
                p_we    = 1'b1;
                p_wdata = p_rdata;
            end
            DP_KS_W2: begin
                p_we    = 1'b1;
                p_waddr = r_j;
                p_wdata = r_si;
                n_i     = i_next;
                n_kpos  = kpos_next;
                // last step: clear j, i wraps to zero by itself
                if (o_sts.cnt_last) begin
                    n_j = '0;
                end
            end
            DP_ENC_INIT: begin
                n_data  = i_data_byte;
                p_re    = 1'b1;
                p_raddr = i_next;
            end
            DP_ENC_J: begin
                n_si    = p_rdata;
                n_i     = i_next;
                n_j     = jj;
                p_re    = 1'b1;
                p_raddr = jj;
            end
            DP_ENC_SW: begin
                n_sj    = p_rdata;
                p_we    = 1'b1;
                p_wdata = p_rdata;
                n_t     = tt;
                p_re    = 1'b1;
                p_raddr = tt;
            end
            DP_ENC_OUT: begin
                p_we    = 1'b1;
                p_waddr = r_j;
                p_wdata = r_si;
                if (i_cmd.out_load) begin
                    n_obyte = r_data ^ ks;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else begin
            r_i <= n_i;
            r_j <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_si    <= n_si;
        r_sj    <= n_sj;
        r_t     <= n_t;
        r_data  <= n_data;
        r_obyte <= n_obyte;
        r_kpos  <= n_kpos;
    end

    assign o_sts.cnt_last = (r_i == 8'hFF);
    assign o_out_byte     = r_obyte;

    a_sched_clears_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_KS_W2 && r_i == 8'hFF) |=> (r_i == 8'd0 && r_j == 8'd0))
        else $error("indices not cleared at end of key schedule");

    a_enc_advances_i: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_ENC_J) |=> (r_i == 8'($past(r_i) + 8'd1)))
        else $error("index i did not advance on keystream step");

    a_write_only_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_we |-> (i_cmd.op == DP_FILL || i_cmd.op == DP_KS_W1 || i_cmd.op == DP_KS_W2 ||
                  i_cmd.op == DP_ENC_SW || i_cmd.op == DP_ENC_OUT))
        else $error("permutation write outside a write step");

endmodule

/* sv/rc4_ctrl.sv */
// RC4 controller: input/output handshake and sequencing of schedule and keystream steps.
module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_command,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_dp_cmd    o_cmd,
    input  t_dp_sts    i_sts
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = DP_NOP;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_command))
                        CMD_LOAD: begin
                            o_cmd.op = DP_KEY_WR;
                        end
                        CMD_SCHED: begin
                            o_cmd.op = DP_SCHED_INIT;
                            n_state  = ST_FILL;
                        end
                        CMD_ENC: begin
                            o_cmd.op = DP_ENC_INIT;
                            n_state  = ST_ENC_J;
                        end
                        CMD_UNUSED: begin
                            // drop the beat
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                o_cmd.op = DP_FILL;
                if (i_sts.cnt_last) begin
                    n_state = ST_KS_RD;
                end
            end
            ST_KS_RD: begin
                o_cmd.op = DP_KS_RD;
                n_state  = ST_KS_ACC;
            end
            ST_KS_ACC: begin
                o_cmd.op = DP_KS_ACC;
                n_state  = ST_KS_W1;
            end
            ST_KS_W1: begin
                o_cmd.op = DP_KS_W1;
                n_state  = ST_KS_W2;
            end
            ST_KS_W2: begin
                o_cmd.op = DP_KS_W2;
                n_state  = i_sts.cnt_last ? ST_IDLE : ST_KS_RD;
            end
            ST_ENC_J: begin
                o_cmd.op = DP_ENC_J;
                n_state  = ST_ENC_SW;
            end
            ST_ENC_SW: begin
                o_cmd.op = DP_ENC_SW;
                n_state  = ST_ENC_OUT;
            end
            ST_ENC_OUT: begin
                // hold here until the output register can take the beat
                o_cmd.op = DP_ENC_OUT;
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_enc_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_ENC) |=>
            (r_state == ST_ENC_J) ##1 (r_state == ST_ENC_SW) ##1 (r_state == ST_ENC_OUT))
        else $error("encrypt beat did not follow the keystream sequence");

    a_out_from_enc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_ENC_OUT))
        else $error("output beat raised outside the output step");

    a_enc_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ENC_OUT && out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished encrypt beat not presented");

    a_sched_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KS_W2 && i_sts.cnt_last) |=> (r_state == ST_IDLE))
        else $error("key schedule did not end after its last step");

endmodule

/* sv/rc4_stream_cipher.sv */
// RC4 stream cipher: key store load, key schedule and keystream XOR of data bytes.
// Encrypt beat: after accept it runs ENC_J, ENC_SW and ENC_OUT, which loads the output
//   register; a new beat waits for IDLE, set by the dependent reads of S[i], S[j] and S[t]
//   and the S[j] write-back in the one permutation RAM; a stalled output beat holds the next
//   encrypt beat in its last step. Key load beat: written to the key RAM at accept.
// Schedule beat: FILL sets S[i] = i, then KS_RD, KS_ACC, KS_W1 and KS_W2 run per permutation step.
// Reset clears the controller, the output valid and indices i and j; the RAMs are not cleared.
module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int KEY_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_key_index,
    input  logic [7:0] i_key_byte,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    rc4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    rc4_dp #(.KEY_BYTES(KEY_BYTES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_key_index (i_key_index),
        .i_key_byte  (i_key_byte),
        .i_data_byte (i_data_byte),
        .o_out_byte  (o_out_byte)
    );

endmodule
